// ----- hw/rtl/skvt_pkg.sv -----
// skvt_pkg: shared constants and types for the small key/value table
// no dependencies; used by small_key_value_table_core
`timescale 1ns / 1ps

package skvt_pkg;

    // table geometry
    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int CFG_W   = 5;

    // reset value of the active slot count register
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP = 2'd0,
        FN_INSERT = 2'd1,
        FN_REMOVE = 2'd2
    } func_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_WRITE = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

endpackage

// ----- hw/rtl/small_key_value_table_core.sv -----
// small_key_value_table_core: fully associative key/value table with a serial scan
// depends on skvt_pkg (constants, opcode and state types)
`timescale 1ns / 1ps

// One operation (lookup, insert or remove) is taken per input beat and gives
// exactly one result beat. A single key comparator walks the active slots from
// index 0, one slot per cycle, so an operation is accepted, scans up to
// slots_in_use slots (at most 16), writes back for a successful insert and
// hands the result to the output register; a rejected item (key zero, unknown
// opcode, no active slots) skips the scan and goes straight to the hand-over.
// Lookups and removes stop at the first match. The input is not ready while
// an operation is in progress; the output register lets the next beat be
// accepted while a finished result is still waiting. The key store is cleared
// by reset; slots_in_use (reset 16, saturating at 16) may only be written
// while the block is idle.
module small_key_value_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    // operation input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] new_value
    input  logic [1:0]  s_tuser,   // [1:0] func
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_out
    output logic        m_tuser,   // [0] success
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data   // slots_in_use
);

    localparam int IDX_W = skvt_pkg::IDX_W;
    localparam int CNT_W = skvt_pkg::CNT_W;
    localparam int KEY_W = skvt_pkg::KEY_W;
    localparam int VAL_W = skvt_pkg::VAL_W;

    skvt_pkg::state_t state_reg, state_next;

    logic [skvt_pkg::CFG_W-1:0]  cfg_reg;
    logic [KEY_W-1:0]            key_arr_reg [skvt_pkg::SLOTS];
    logic [VAL_W-1:0]            val_arr_reg [skvt_pkg::SLOTS];

    logic [skvt_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [KEY_W-1:0]            key_reg, key_next;
    logic [VAL_W-1:0]            nval_reg, nval_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic                        free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic                        ok_reg, ok_next;
    logic [VAL_W-1:0]            res_reg, res_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        m_success_reg, m_success_next;
    logic [VAL_W-1:0]            m_value_reg, m_value_next;

    logic                        in_beat;
    logic                        out_free;
    logic [CNT_W-1:0]            active_n;
    logic                        item_ok;
    logic                        hit;
    logic                        empty;
    logic                        last;
    logic                        scan_end;
    logic                        go_write;

    logic                        key_we;
    logic [IDX_W-1:0]            key_waddr;
    logic [KEY_W-1:0]            key_wdata;
    logic                        val_we;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= skvt_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            cfg_reg <= cfg_data;
        end
    end

    // active slot count, saturated at the table size
    always_comb begin
        if (32'(cfg_reg) > skvt_pkg::SLOTS) begin
            active_n = CNT_W'(skvt_pkg::SLOTS);
        end else begin
            active_n = CNT_W'(cfg_reg);
        end
    end

    // handshakes
    assign s_tready = (state_reg == skvt_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // validity of a new item: nonzero key, known opcode, something to scan
    always_comb begin
        unique case (s_tuser)
            skvt_pkg::FN_LOOKUP,
            skvt_pkg::FN_INSERT,
            skvt_pkg::FN_REMOVE: item_ok = (s_tdata[31:0] != '0) && (active_n != '0);
            default:             item_ok = 1'b0;
        endcase
    end

    // shared comparator on the slot under the scan pointer
    assign hit   = (key_arr_reg[idx_reg] == key_reg);
    assign empty = (key_arr_reg[idx_reg] == '0);
    assign last  = ({1'b0, idx_reg} == (active_n - CNT_W'(1)));

    // scan termination per opcode
    always_comb begin
        scan_end = last;
        go_write = 1'b0;
        unique case (func_reg)
            skvt_pkg::FN_LOOKUP,
            skvt_pkg::FN_REMOVE: scan_end = hit || last;
            skvt_pkg::FN_INSERT: begin
                scan_end = hit || last;
                go_write = !hit && last && (free_vld_reg || empty);
            end
            default:             scan_end = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            skvt_pkg::ST_IDLE: begin
                if (in_beat) begin
                    state_next = item_ok ? skvt_pkg::ST_SCAN : skvt_pkg::ST_DONE;
                end
            end
            skvt_pkg::ST_SCAN: begin
                if (go_write) begin
                    state_next = skvt_pkg::ST_WRITE;
                end else if (scan_end) begin
                    state_next = skvt_pkg::ST_DONE;
                end
            end
            skvt_pkg::ST_WRITE: begin
                state_next = skvt_pkg::ST_DONE;
            end
            skvt_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = skvt_pkg::ST_IDLE;
                end
            end
            default: state_next = skvt_pkg::ST_IDLE;
        endcase
    end

    // datapath and store write controls
    always_comb begin
        func_next      = func_reg;
        key_next       = key_reg;
        nval_next      = nval_reg;
        idx_next       = idx_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        ok_next        = ok_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_success_next = m_success_reg;
        m_value_next   = m_value_reg;
        key_we         = 1'b0;
        key_waddr      = idx_reg;
        key_wdata      = '0;
        val_we         = 1'b0;

        unique case (state_reg)
            skvt_pkg::ST_IDLE: begin
                // capture the operation
                if (in_beat) begin
                    func_next     = s_tuser;
                    key_next      = s_tdata[31:0];
                    nval_next     = s_tdata[63:32];
                    idx_next      = '0;
                    free_vld_next = 1'b0;
                    free_idx_next = '0;
                    ok_next       = 1'b0;
                    res_next      = '0;
                end
            end
            skvt_pkg::ST_SCAN: begin
                // one slot per cycle
                unique case (func_reg)
                    skvt_pkg::FN_LOOKUP: begin
                        if (hit) begin
                            ok_next  = 1'b1;
                            res_next = val_arr_reg[idx_reg];
                        end
                    end
                    skvt_pkg::FN_REMOVE: begin
                        if (hit) begin
                            ok_next   = 1'b1;
                            res_next  = val_arr_reg[idx_reg];
                            key_we    = 1'b1;
                            key_waddr = idx_reg;
                            key_wdata = '0;
                        end
                    end
                    skvt_pkg::FN_INSERT: begin
                        // remember the highest free slot seen so far
                        if (!hit && empty) begin
                            free_vld_next = 1'b1;
                            free_idx_next = idx_reg;
                        end
                    end
                    default: ;
                endcase
                if (!scan_end) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            skvt_pkg::ST_WRITE: begin
                // insert write-back into the chosen free slot
                key_we    = 1'b1;
                key_waddr = free_idx_reg;
                key_wdata = key_reg;
                val_we    = 1'b1;
                ok_next   = 1'b1;
            end
            skvt_pkg::ST_DONE: begin
                // hand the result to the output register
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_success_next = ok_reg;
                    m_value_next   = res_reg;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= skvt_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        nval_reg      <= nval_next;
        idx_reg       <= idx_next;
        free_vld_reg  <= free_vld_next;
        free_idx_reg  <= free_idx_next;
        ok_reg        <= ok_next;
        res_reg       <= res_next;
        m_success_reg <= m_success_next;
        m_value_reg   <= m_value_next;
    end

    // key store, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < skvt_pkg::SLOTS; i++) begin
                key_arr_reg[i] <= '0;
            end
        end else if (key_we) begin
            key_arr_reg[key_waddr] <= key_wdata;
        end
    end

    // value store, written only together with a key
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_arr_reg[free_idx_reg] <= nval_reg;
        end
    end

    // outputs
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_success_reg;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for small_key_value_table_core
// depends on skvt_pkg and the core; a table model predicts every result beat

module testbench;

    // opcode with no meaning to the core
    localparam logic [skvt_pkg::FUNC_W-1:0] FN_UNKNOWN = 2'd3;
    // length of the long receiver hold, in cycles
    localparam int HOLD_CYCLES = 120;
    // cycles without any beat before the run is abandoned
    localparam int STALL_LIMIT = 3000;
    localparam int KEY_POOL    = 24;

    typedef struct packed {
        logic                       success;
        logic [skvt_pkg::VAL_W-1:0] value;
    } kv_result_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata   = '0;   // [31:0] key, [63:32] new_value
    logic [1:0]       s_tuser   = '0;   // [1:0] func
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;          // [31:0] value_out
    logic             m_tuser;          // [0] success
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [skvt_pkg::CFG_W-1:0] cfg_data = skvt_pkg::CFG_RESET;

    // bench control
    logic             quiet     = 1'b0;
    logic             hold_req  = 1'b0;
    bit               hold_done = 1'b0;
    int unsigned      rx_stall  = 0;
    int unsigned      errors    = 0;
    int unsigned      idle_cycles = 0;

    // table model and the results it has promised
    logic [skvt_pkg::KEY_W-1:0] model_key [skvt_pkg::SLOTS];
    logic [skvt_pkg::VAL_W-1:0] model_val [skvt_pkg::SLOTS];
    logic [skvt_pkg::CFG_W-1:0] model_span;
    logic [skvt_pkg::KEY_W-1:0] key_pool [KEY_POOL];
    kv_result_t       pending_results [$];

    small_key_value_table_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock, 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // table behaviour for one accepted operation
    function automatic kv_result_t predict_op(input logic [skvt_pkg::FUNC_W-1:0] fn,
                                              input logic [skvt_pkg::KEY_W-1:0] key,
                                              input logic [skvt_pkg::VAL_W-1:0] val);
        kv_result_t res;
        int         active;
        int         free_slot;
        bit         found;
        res       = '0;
        found     = 1'b0;
        free_slot = -1;
        active    = (model_span > skvt_pkg::SLOTS) ? skvt_pkg::SLOTS : int'(model_span);
        if (key != '0) begin
            case (fn)
                skvt_pkg::FN_LOOKUP, skvt_pkg::FN_REMOVE: begin
                    for (int i = 0; i < active && !found; i++) begin
                        if (model_key[i] == key) begin
                            found       = 1'b1;
                            res.success = 1'b1;
                            res.value   = model_val[i];
                            if (fn == skvt_pkg::FN_REMOVE)
                                model_key[i] = '0;
                        end
                    end
                end
                skvt_pkg::FN_INSERT: begin
                    // last free slot before any match wins
                    for (int i = 0; i < active && !found; i++) begin
                        if (model_key[i] == key)
                            found = 1'b1;
                        else if (model_key[i] == '0)
                            free_slot = i;
                    end
                    if (!found && free_slot >= 0) begin
                        model_key[free_slot] = key;
                        model_val[free_slot] = val;
                        res.success          = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    // one operation beat, with an optional gap in front
    task automatic send_op(input logic [skvt_pkg::FUNC_W-1:0] fn,
                           input logic [skvt_pkg::KEY_W-1:0] key,
                           input logic [skvt_pkg::VAL_W-1:0] val);
        int unsigned gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, key};
        s_tuser  <= fn;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_op(fn, key, val));
    endtask

    // stop offering and wait until every promised result has gone out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // active slot count, only written with the core idle
    task automatic write_slots_in_use(input logic [skvt_pkg::CFG_W-1:0] span);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= span;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        model_span = span;
    endtask

    // mostly pool keys so the table fills and hits; some noise and rejects
    task automatic send_random_op(input int span);
        logic [skvt_pkg::FUNC_W-1:0] fn;
        logic [skvt_pkg::KEY_W-1:0]  key;
        logic [skvt_pkg::VAL_W-1:0]  val;
        int unsigned                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 90) begin
            pick = $urandom_range(0, 99);
            fn   = (pick < 40) ? skvt_pkg::FN_INSERT :
                   (pick < 70) ? skvt_pkg::FN_LOOKUP : skvt_pkg::FN_REMOVE;
            key  = key_pool[$urandom_range(0, span - 1)];
        end else if (pick < 94) begin
            fn  = skvt_pkg::FUNC_W'($urandom_range(0, 2));
            key = $urandom;
        end else if (pick < 97) begin
            fn  = skvt_pkg::FUNC_W'($urandom_range(0, 3));
            key = '0;
        end else begin
            fn  = FN_UNKNOWN;
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        end
        pick = $urandom_range(0, 7);
        val  = (pick == 0) ? '0 : (pick == 1) ? '1 : skvt_pkg::VAL_W'($urandom);
        send_op(fn, key, val);
    endtask

    // empty table after reset
    task automatic test_empty_table();
        send_op(skvt_pkg::FN_LOOKUP, 32'h1234_5678, 32'h0);
        send_op(skvt_pkg::FN_REMOVE, 32'h1234_5678, 32'h0);
    endtask

    // each operation, duplicates, stored zero value, rejected items
    task automatic test_basic_ops();
        send_op(skvt_pkg::FN_INSERT, '1, '1);
        send_op(skvt_pkg::FN_LOOKUP, '1, '0);
        send_op(skvt_pkg::FN_INSERT, '1, 32'h5555_5555);
        send_op(skvt_pkg::FN_INSERT, 32'h1, '0);
        send_op(skvt_pkg::FN_LOOKUP, 32'h1, '1);
        send_op(skvt_pkg::FN_REMOVE, '1, '0);
        send_op(skvt_pkg::FN_LOOKUP, '1, '0);
        send_op(skvt_pkg::FN_REMOVE, '1, '0);
        send_op(skvt_pkg::FN_LOOKUP, '0, '1);
        send_op(skvt_pkg::FN_INSERT, '0, '1);
        send_op(skvt_pkg::FN_REMOVE, '0, '1);
        send_op(FN_UNKNOWN, 32'h1, '1);
        send_op(FN_UNKNOWN, '0, '0);
    endtask

    // small, zero and saturating slot counts
    task automatic test_scan_limits();
        write_slots_in_use(skvt_pkg::CFG_W'(2));
        send_op(skvt_pkg::FN_INSERT, 32'hA5A5_0001, 32'h1111_1111);
        send_op(skvt_pkg::FN_INSERT, 32'h5A5A_0002, 32'h2222_2222);
        send_op(skvt_pkg::FN_INSERT, 32'h8000_0000, 32'h3333_3333);
        send_op(skvt_pkg::FN_LOOKUP, 32'hA5A5_0001, '0);
        send_op(skvt_pkg::FN_LOOKUP, 32'h1, '0);
        write_slots_in_use(skvt_pkg::CFG_W'(0));
        send_op(skvt_pkg::FN_LOOKUP, 32'hA5A5_0001, '0);
        send_op(skvt_pkg::FN_INSERT, 32'h4444_4444, 32'h4444_4444);
        send_op(skvt_pkg::FN_REMOVE, 32'hA5A5_0001, '0);
        write_slots_in_use('1);
        send_op(skvt_pkg::FN_LOOKUP, 32'h1, '0);
        send_op(skvt_pkg::FN_REMOVE, 32'hA5A5_0001, '0);
    endtask

    // receiver holds off for a long stretch while beats keep coming
    task automatic test_backpressure();
        write_slots_in_use(skvt_pkg::CFG_W'(16));
        hold_req <= 1'b1;
        repeat (40) send_random_op(KEY_POOL);
    endtask

    // sender pauses until the core has handed back everything
    task automatic test_pause_drain();
        repeat (20) send_random_op(KEY_POOL);
        wait_drained();
        repeat (20) send_random_op(KEY_POOL);
    endtask

    // random traffic over a spread of slot counts
    task automatic test_random_sweep();
        write_slots_in_use(skvt_pkg::CFG_W'(16));
        repeat (60) send_random_op(KEY_POOL);
        write_slots_in_use(skvt_pkg::CFG_W'(1));
        repeat (80) send_random_op(4);
        write_slots_in_use('1);
        repeat (60) send_random_op(KEY_POOL);
        write_slots_in_use(skvt_pkg::CFG_W'(2));
        repeat (80) send_random_op(6);
        write_slots_in_use(skvt_pkg::CFG_W'(0));
        repeat (20) send_random_op(KEY_POOL);
        write_slots_in_use(skvt_pkg::CFG_W'(7));
        repeat (80) send_random_op(12);
        write_slots_in_use(skvt_pkg::CFG_W'($urandom_range(1, 16)));
        repeat (80) send_random_op(KEY_POOL);
        // closing stretch with no idling on either side
        write_slots_in_use(skvt_pkg::CFG_W'(16));
        quiet <= 1'b1;
        repeat (100) send_random_op(KEY_POOL);
    endtask

    // receiver: long hold once, random short stalls otherwise
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rx_stall  = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall  = rx_stall - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rx_stall  = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result beat against the oldest prediction
    always @(posedge aclk) begin
        kv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: success %0b value_out %h", m_tuser, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.success) begin
                    $error("success: expected %0b, got %0b", want.success, m_tuser);
                    errors++;
                end
                if (m_tdata !== want.value) begin
                    $error("value_out: expected %h, got %h", want.value, m_tdata);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat at all
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < skvt_pkg::SLOTS; i++) begin
            model_key[i] = '0;
            model_val[i] = '0;
        end
        model_span = skvt_pkg::CFG_RESET;
        // key pool with the corner keys up front
        key_pool[0] = '1;
        key_pool[1] = 32'h1;
        key_pool[2] = 32'h8000_0000;
        for (int i = 3; i < KEY_POOL; i++) begin
            do key_pool[i] = $urandom; while (key_pool[i] == '0);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_basic_ops();
        test_scan_limits();
        test_backpressure();
        test_pause_drain();
        test_random_sweep();

        wait_drained();
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
